// ===== rtl/ita_pkg.sv =====
package ita_pkg;

    // Field and datapath widths.
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned HALF_W      = 32;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned BIT_CNT_W   = $clog2(VALUE_W + 1);
    localparam int unsigned STEP_BITS   = 4;

    // Text limits.
    localparam int unsigned RESULT_LIMIT = 20;
    localparam int unsigned CNT_W        = $clog2(RESULT_LIMIT);
    localparam int unsigned DEC_DIGITS   = 20;
    localparam int unsigned DEC_RADIX    = 10;
    localparam int unsigned HEX_RADIX    = 16;
    localparam int unsigned NIL_IDX_W    = 3;
    localparam logic [NIL_IDX_W-1:0] NIL_LAST = 3'd4;

    // Queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // ASCII codes used outside the digit tables.
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

    typedef enum logic [OP_W-1:0] {
        OP_DEC    = 2'd0,
        OP_HEX_LO = 2'd1,
        OP_HEX_UP = 2'd2,
        OP_PTR    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        MODE_DEC,
        MODE_HEX_LO,
        MODE_HEX_UP,
        MODE_PTR,
        MODE_NIL
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_task;

    typedef struct packed {
        t_mode mode;
        logic  neg;
    } t_head;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_DONE
    } t_conv_st;

    typedef enum logic [2:0] {
        EM_IDLE,
        EM_SIGN,
        EM_ZERO,
        EM_X,
        EM_NIL,
        EM_DIGIT
    } t_emit_st;

    function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic upper);
        logic [CHAR_W-1:0] d8;
        d8 = {{(CHAR_W - DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(10)) begin
            return CH_ZERO + d8;
        end else if (upper) begin
            return 8'h41 + d8 - 8'd10;
        end else begin
            return 8'h61 + d8 - 8'd10;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] nil_char(logic [NIL_IDX_W-1:0] k);
        logic [CHAR_W-1:0] c;
        unique case (k)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6E;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6C;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/ita_front.sv =====
module ita_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ita_pkg::OP_W-1:0]     i_operation,
    input  logic [ita_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_push,
    output ita_pkg::t_task               o_item,
    input  logic                         i_q_full
);
    import ita_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_task r_item;
    t_task n_item;
    logic  accept;

    // Sort the item into its mode and form the magnitude to convert.
    always_comb begin
        n_item.neg  = 1'b0;
        n_item.mag  = i_value;
        n_item.mode = MODE_DEC;
        unique case (t_op'(i_operation))
            OP_DEC: begin
                n_item.mode = MODE_DEC;
                if (i_value[VALUE_W-1]) begin
                    n_item.neg = 1'b1;
                    n_item.mag = ~i_value + VALUE_W'(1);
                end
            end
            OP_HEX_LO: n_item.mode = MODE_HEX_LO;
            OP_HEX_UP: n_item.mode = MODE_HEX_UP;
            OP_PTR: begin
                n_item.mode = (i_value == '0) ? MODE_NIL : MODE_PTR;
            end
            default: n_item.mode = MODE_DEC;
        endcase
    end

    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_item  = r_item;
    assign n_valid = accept || o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/ita_fifo.sv =====
module ita_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ita_pkg::t_task i_item,
    output logic           o_full,
    output logic           o_valid,
    output ita_pkg::t_task o_item,
    input  logic           i_pop
);
    import ita_pkg::*;

    localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

    t_task            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0]  r_wptr;
    logic [PtrW-1:0]  r_rptr;
    logic [CntW-1:0]  r_count;
    logic [PtrW-1:0]  n_wptr;
    logic [PtrW-1:0]  n_rptr;
    logic [CntW-1:0]  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PtrW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ===== rtl/ita_conv.sv =====
module ita_conv #(
    parameter  int unsigned NUM_DIGITS = 20,
    parameter  int unsigned PTR_RADIX  = 16,
    localparam int unsigned IdxW       = $clog2(NUM_DIGITS)
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_q_valid,
    input  ita_pkg::t_task                                i_q_item,
    output logic                                          o_q_pop,
    output logic                                          o_cv_valid,
    output ita_pkg::t_head                                o_head,
    output logic [NUM_DIGITS-1:0][ita_pkg::DIGIT_W-1:0]   o_digits,
    output logic [IdxW-1:0]                               o_top_idx,
    input  logic                                          i_take
);
    import ita_pkg::*;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_dvec;

    localparam int unsigned PfxLevels = $clog2(NUM_DIGITS + 1);
    localparam bit          PtrOdd    = (PTR_RADIX % 2) == 1;

    t_conv_st                r_state;
    t_conv_st                n_state;
    logic [VALUE_W-1:0]      r_sreg;
    logic [VALUE_W-1:0]      n_sreg;
    logic [BIT_CNT_W-1:0]    r_bits;
    logic [BIT_CNT_W-1:0]    n_bits;
    logic [RADIX_W-1:0]      r_radix;
    logic [RADIX_W-1:0]      n_radix;
    logic                    r_odd;
    logic                    n_odd;
    t_dvec                   r_acc;
    t_dvec                   n_acc;
    logic [NUM_DIGITS-1:0]   r_used;
    logic [NUM_DIGITS-1:0]   n_used;
    t_head                   r_head;
    t_head                   n_head;
    t_dvec                   acc_e;
    logic [NUM_DIGITS-1:0]   used_e;
    t_dvec                   acc_o;
    logic [NUM_DIGITS-1:0]   used_o;
    logic                    load;
    logic [NUM_DIGITS-1:0]   used_top;
    logic [NUM_DIGITS-1:0]   lead;

    function automatic logic [NUM_DIGITS-1:0] nonzero(t_dvec acc);
        logic [NUM_DIGITS-1:0] nz;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            nz[i] = |acc[i];
        end
        return nz;
    endfunction

    // One doubling step with an even radix: a digit's carry depends on that digit alone.
    function automatic t_dvec step_even(t_dvec acc, logic bin, logic [RADIX_W-1:0] radix);
        logic [NUM_DIGITS-1:0] gen;
        logic [NUM_DIGITS-1:0] cin;
        logic [RADIX_W-1:0]    dbl;
        logic [RADIX_W-1:0]    sum;
        t_dvec                 res;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            dbl    = {acc[i], 1'b0};
            gen[i] = (dbl >= radix);
        end
        cin = {gen[NUM_DIGITS-2:0], bin};
        for (int i = 0; i < NUM_DIGITS; i++) begin
            dbl    = {acc[i], 1'b0};
            sum    = dbl - (gen[i] ? radix : '0) + {{(RADIX_W - 1){1'b0}}, cin[i]};
            res[i] = sum[DIGIT_W-1:0];
        end
        return res;
    endfunction

    // One doubling step with an odd radix: a digit of (radix-1)/2 passes a carry on,
    // so the carries are resolved by a parallel prefix network.
    function automatic t_dvec step_odd(t_dvec acc, logic bin, logic [RADIX_W-1:0] radix);
        logic [NUM_DIGITS:0]   g;
        logic [NUM_DIGITS:0]   p;
        logic [NUM_DIGITS:0]   gn;
        logic [NUM_DIGITS:0]   pn;
        logic [RADIX_W-1:0]    dbl;
        logic [RADIX_W-1:0]    sum;
        t_dvec                 res;
        g[0] = bin;
        p[0] = 1'b0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            dbl      = {acc[i], 1'b0};
            g[i + 1] = (dbl >= radix);
            p[i + 1] = ((dbl + RADIX_W'(1)) == radix);
        end
        for (int lvl = 0; lvl < PfxLevels; lvl++) begin
            gn = g;
            pn = p;
            for (int i = 0; i <= NUM_DIGITS; i++) begin
                if (i >= (1 << lvl)) begin
                    gn[i] = g[i] | (p[i] & g[i - (1 << lvl)]);
                    pn[i] = p[i] & p[i - (1 << lvl)];
                end
            end
            g = gn;
            p = pn;
        end
        for (int i = 0; i < NUM_DIGITS; i++) begin
            dbl    = {acc[i], 1'b0};
            sum    = dbl + {{(RADIX_W - 1){1'b0}}, g[i]} - (g[i + 1] ? radix : '0);
            res[i] = sum[DIGIT_W-1:0];
        end
        return res;
    endfunction

    // Four bits a cycle for an even radix.
    always_comb begin
        acc_e  = r_acc;
        used_e = r_used;
        for (int s = 0; s < STEP_BITS; s++) begin
            acc_e  = step_even(acc_e, r_sreg[VALUE_W - 1 - s], r_radix);
            used_e = used_e | nonzero(acc_e);
        end
    end

    generate
        if (PtrOdd) begin : g_odd
            always_comb begin
                acc_o  = step_odd(r_acc, r_sreg[VALUE_W-1], r_radix);
                used_o = r_used | nonzero(acc_o);
            end
        end else begin : g_even
            assign acc_o  = acc_e;
            assign used_o = used_e;
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_sreg  = r_sreg;
        n_bits  = r_bits;
        n_radix = r_radix;
        n_odd   = r_odd;
        n_acc   = r_acc;
        n_used  = r_used;
        n_head  = r_head;
        load    = 1'b0;
        unique case (r_state)
            CV_IDLE: load = i_q_valid;
            CV_RUN: begin
                if (r_odd) begin
                    n_acc  = acc_o;
                    n_used = used_o;
                    n_sreg = r_sreg << 1;
                    n_bits = r_bits - BIT_CNT_W'(1);
                    if (r_bits == BIT_CNT_W'(1)) begin
                        n_state = CV_DONE;
                    end
                end else begin
                    n_acc  = acc_e;
                    n_used = used_e;
                    n_sreg = r_sreg << STEP_BITS;
                    n_bits = r_bits - BIT_CNT_W'(STEP_BITS);
                    if (r_bits == BIT_CNT_W'(STEP_BITS)) begin
                        n_state = CV_DONE;
                    end
                end
            end
            CV_DONE: begin
                if (i_take) begin
                    n_state = CV_IDLE;
                    load    = i_q_valid;
                end
            end
            default: n_state = CV_IDLE;
        endcase

        if (load) begin
            n_acc       = '0;
            n_used      = '0;
            n_head.mode = i_q_item.mode;
            n_head.neg  = i_q_item.neg;
            n_sreg      = i_q_item.mag;
            n_bits      = BIT_CNT_W'(VALUE_W);
            n_odd       = 1'b0;
            n_radix     = RADIX_W'(HEX_RADIX);
            n_state     = CV_RUN;
            unique case (i_q_item.mode)
                MODE_DEC: n_radix = RADIX_W'(DEC_RADIX);
                MODE_HEX_LO, MODE_HEX_UP: begin
                    n_sreg = {i_q_item.mag[HALF_W-1:0], {(VALUE_W - HALF_W){1'b0}}};
                    n_bits = BIT_CNT_W'(HALF_W);
                end
                MODE_PTR: begin
                    n_radix = RADIX_W'(PTR_RADIX);
                    n_odd   = PtrOdd;
                end
                MODE_NIL: n_state = CV_DONE;
                default:  n_state = CV_DONE;
            endcase
        end
    end

    // The used digits form a thermometer; its top edge is the leading digit.
    always_comb begin
        used_top    = r_used;
        used_top[0] = 1'b1;
        lead        = used_top & ~{1'b0, used_top[NUM_DIGITS-1:1]};
        o_top_idx   = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            o_top_idx = o_top_idx | (lead[i] ? IdxW'(i) : '0);
        end
    end

    assign o_q_pop    = load;
    assign o_cv_valid = (r_state == CV_DONE);
    assign o_head     = r_head;
    assign o_digits   = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sreg  <= n_sreg;
        r_bits  <= n_bits;
        r_radix <= n_radix;
        r_odd   <= n_odd;
        r_acc   <= n_acc;
        r_used  <= n_used;
        r_head  <= n_head;
    end

endmodule

// ===== rtl/ita_emit.sv =====
module ita_emit #(
    parameter  int unsigned NUM_DIGITS = 20,
    localparam int unsigned IdxW       = $clog2(NUM_DIGITS)
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cv_valid,
    input  ita_pkg::t_head                                i_head,
    input  logic [NUM_DIGITS-1:0][ita_pkg::DIGIT_W-1:0]   i_digits,
    input  logic [IdxW-1:0]                               i_top_idx,
    output logic                                          o_take,
    output logic                                          o_valid,
    input  logic                                          i_stall,
    output logic [ita_pkg::CHAR_W-1:0]                    o_character,
    output logic                                          o_last_char
);
    import ita_pkg::*;

    t_emit_st                              r_state;
    t_emit_st                              n_state;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]    r_digits;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]    n_digits;
    logic [IdxW-1:0]                       r_pos;
    logic [IdxW-1:0]                       n_pos;
    logic                                  r_upper;
    logic                                  n_upper;
    logic [NIL_IDX_W-1:0]                  r_nil_idx;
    logic [NIL_IDX_W-1:0]                  n_nil_idx;
    logic [CNT_W-1:0]                      r_count;
    logic [CNT_W-1:0]                      n_count;
    logic                                  r_out_valid;
    logic                                  n_out_valid;
    logic [CHAR_W-1:0]                     r_char;
    logic [CHAR_W-1:0]                     n_char;
    logic                                  r_last;
    logic                                  n_last;
    logic [CHAR_W-1:0]                     ch;
    logic                                  last_text;
    logic                                  last;
    t_emit_st                              st_next;
    logic                                  adv;
    logic                                  fire;

    always_comb begin
        ch        = CH_ZERO;
        last_text = 1'b0;
        st_next   = r_state;
        unique case (r_state)
            EM_IDLE: st_next = EM_IDLE;
            EM_SIGN: begin
                ch      = CH_MINUS;
                st_next = EM_DIGIT;
            end
            EM_ZERO: begin
                ch      = CH_ZERO;
                st_next = EM_X;
            end
            EM_X: begin
                ch      = CH_X;
                st_next = EM_DIGIT;
            end
            EM_NIL: begin
                ch        = nil_char(r_nil_idx);
                last_text = (r_nil_idx == NIL_LAST);
            end
            EM_DIGIT: begin
                ch        = digit_char(r_digits[r_pos], r_upper);
                last_text = (r_pos == '0);
            end
            default: st_next = EM_IDLE;
        endcase

        // Text that would run past the result limit is cut short.
        last   = last_text || (r_count == CNT_W'(RESULT_LIMIT - 1));
        adv    = !r_out_valid || !i_stall;
        fire   = (r_state != EM_IDLE) && adv;
        o_take = i_cv_valid && ((r_state == EM_IDLE) || (fire && last));

        n_state     = r_state;
        n_digits    = r_digits;
        n_pos       = r_pos;
        n_upper     = r_upper;
        n_nil_idx   = r_nil_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;

        if (fire) begin
            n_out_valid = 1'b1;
            n_char      = ch;
            n_last      = last;
            n_count     = r_count + CNT_W'(1);
            n_state     = last ? EM_IDLE : st_next;
            if (r_state == EM_NIL) begin
                n_nil_idx = r_nil_idx + NIL_IDX_W'(1);
            end
            if (r_state == EM_DIGIT) begin
                n_pos = r_pos - IdxW'(1);
            end
        end else if (adv) begin
            n_out_valid = 1'b0;
        end

        if (o_take) begin
            n_digits  = i_digits;
            n_pos     = i_top_idx;
            n_upper   = (i_head.mode == MODE_HEX_UP);
            n_nil_idx = '0;
            n_count   = '0;
            unique case (i_head.mode)
                MODE_DEC:  n_state = i_head.neg ? EM_SIGN : EM_DIGIT;
                MODE_PTR:  n_state = EM_ZERO;
                MODE_NIL:  n_state = EM_NIL;
                default:   n_state = EM_DIGIT;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EM_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits  <= n_digits;
        r_pos     <= n_pos;
        r_upper   <= n_upper;
        r_nil_idx <= n_nil_idx;
        r_count   <= n_count;
        r_char    <= n_char;
        r_last    <= n_last;
    end

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter.
//
// Input channel (i_valid / o_stall): an item is an operation code and a 64-bit
// value, taken at a clock edge where i_valid is high and o_stall is low. Output
// channel (o_valid / i_stall): one ASCII character per transfer and a text per item,
// most significant digit first, with o_last_char marking the final character of
// each text. Texts are cut at twenty characters.
//
// The front registers and classifies each item into a two-entry queue. The
// converter turns the magnitude into digits by shift-and-correct, four bits a
// cycle, or one bit a cycle for pointer values when the pointer radix is odd;
// hex uses only the low 32 bits and "(nil)" needs no conversion. The emitter
// serialises the text from its own copy of the digits, so conversion of the next
// item overlaps emission of this one. The first character passes through the
// front register, the queue, the converter and the emitter's output register.
// Reset is synchronous and empties every stage. While the receiver stalls, the
// character on the port holds and the queue fills up, after which o_stall rises.
module integer_to_ascii_formatter #(
    parameter int unsigned POINTER_RADIX = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ita_pkg::OP_W-1:0]     i_operation,
    input  logic [ita_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ita_pkg::CHAR_W-1:0]   o_character,
    output logic                         o_last_char
);
    import ita_pkg::*;

    // A radix outside two to sixteen is pulled back into that range.
    localparam int unsigned PtrRadix = (POINTER_RADIX < 2)  ? 2 :
                                       (POINTER_RADIX > 16) ? 16 : POINTER_RADIX;

    // Number of pointer digits needed for the largest 64-bit value.
    function automatic int unsigned ptr_digits();
        logic [VALUE_W-1:0] m;
        int unsigned        n;
        m = '1;
        n = 0;
        for (int k = 0; k < VALUE_W; k++) begin
            if (m != '0) begin
                m = m / PtrRadix;
                n++;
            end
        end
        return n;
    endfunction

    localparam int unsigned PtrDigits = ptr_digits();
    localparam int unsigned NumDigits = (PtrDigits > DEC_DIGITS) ? PtrDigits : DEC_DIGITS;
    localparam int unsigned IdxW      = $clog2(NumDigits);

    logic                               push;
    t_task                              front_item;
    logic                               q_full;
    logic                               q_valid;
    t_task                              q_item;
    logic                               q_pop;
    logic                               cv_valid;
    t_head                              cv_head;
    logic [NumDigits-1:0][DIGIT_W-1:0]  cv_digits;
    logic [IdxW-1:0]                    cv_top_idx;
    logic                               take;

    ita_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_push      (push),
        .o_item      (front_item),
        .i_q_full    (q_full)
    );

    ita_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    ita_conv #(
        .NUM_DIGITS (NumDigits),
        .PTR_RADIX  (PtrRadix)
    ) u_conv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_cv_valid (cv_valid),
        .o_head     (cv_head),
        .o_digits   (cv_digits),
        .o_top_idx  (cv_top_idx),
        .i_take     (take)
    );

    ita_emit #(
        .NUM_DIGITS (NumDigits)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cv_valid  (cv_valid),
        .i_head      (cv_head),
        .i_digits    (cv_digits),
        .i_top_idx   (cv_top_idx),
        .o_take      (take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

endmodule
